/* rtl/arpm_pkg.sv */
// shared types and constants for the arp ip/mac binding monitor
package arpm_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [15:0] MIN_ARP_FRAME  = 16'd42;
  localparam logic [15:0] ETHER_KIND_ARP = 16'h0806;
  localparam logic [15:0] HW_KIND_ETHER  = 16'd1;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [31:0] IP_ZERO        = 32'd0;

  typedef enum logic [1:0] {
    CMD_IGNORE = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    EV_IGNORED  = 3'd0,
    EV_LEARNED  = 3'd1,
    EV_SAME     = 3'd2,
    EV_CONFLICT = 3'd3,
    EV_FULL     = 3'd4,
    EV_CLEARED  = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_EMIT = 2'd2
  } back_state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] ip;
    logic [47:0] mac;
  } q_entry_t;

endpackage

/* rtl/arp_ip_mac_binding_monitor.sv */
// arp ip/mac binding monitor: a clear or ignored beat is popped from the queue and its result
// registered in the emit state; a checked request scans the table one entry per cycle on the
// registered memory read port, stopping early on a match, then learns or reports a full table
// one item at a time in the table engine, which also waits while results are stalled;
// a two-entry queue keeps the front accepting while the engine is busy, until it fills
// reset clears the binding count, the queue and the result valid flag, not the table memory or result data
module arp_ip_mac_binding_monitor #(
  parameter int TABLE_ENTRIES = arpm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        func,
  input  logic [15:0] frame_length,
  input  logic [15:0] captured_length,
  input  logic [15:0] ether_kind,
  input  logic [15:0] hardware_kind,
  input  logic [15:0] arp_operation,
  input  logic [31:0] sender_ip,
  input  logic [47:0] sender_mac,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  event_res,
  output logic [47:0] bound_mac,
  output logic [6:0]  entries_used
);

  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               pop;
  arpm_pkg::q_entry_t push_data;
  arpm_pkg::q_entry_t q_data;

  arpm_front u_front (
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .func            (func),
    .frame_length    (frame_length),
    .captured_length (captured_length),
    .ether_kind      (ether_kind),
    .hardware_kind   (hardware_kind),
    .arp_operation   (arp_operation),
    .sender_ip       (sender_ip),
    .sender_mac      (sender_mac),
    .q_full          (q_full),
    .push            (push),
    .push_data       (push_data)
  );

  arpm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  arpm_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .event_res    (event_res),
    .bound_mac    (bound_mac),
    .entries_used (entries_used)
  );

  // bound mac only carries a value for a seen or conflicting binding
  a_mac_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !(event_res == arpm_pkg::EV_SAME || event_res == arpm_pkg::EV_CONFLICT)
    |-> bound_mac == 48'd0)
    else $error("bound_mac nonzero for event %0d", event_res);

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && event_res == arpm_pkg::EV_CLEARED |-> entries_used == 7'd0)
    else $error("table not empty after clear");

  // a queued command must never be popped while no entry is held
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("queue popped while empty");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> event_res <= arpm_pkg::EV_CLEARED)
    else $error("event code out of range");

endmodule

/* rtl/arpm_front.sv */
// front end: accepts frame beats and classifies them into table commands
module arpm_front (
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              func,
  input  logic [15:0]       frame_length,
  input  logic [15:0]       captured_length,
  input  logic [15:0]       ether_kind,
  input  logic [15:0]       hardware_kind,
  input  logic [15:0]       arp_operation,
  input  logic [31:0]       sender_ip,
  input  logic [47:0]       sender_mac,
  input  logic              q_full,
  output logic              push,
  output arpm_pkg::q_entry_t push_data
);

  logic is_request;

  assign is_request = (frame_length >= arpm_pkg::MIN_ARP_FRAME) &&
                      (captured_length >= arpm_pkg::MIN_ARP_FRAME) &&
                      (ether_kind == arpm_pkg::ETHER_KIND_ARP) &&
                      (hardware_kind == arpm_pkg::HW_KIND_ETHER) &&
                      (arp_operation == arpm_pkg::ARP_OP_REQUEST) &&
                      (sender_ip != arpm_pkg::IP_ZERO);

  assign item_stall = q_full;
  assign push       = item_valid && !q_full;

  always_comb begin
    push_data.ip  = sender_ip;
    push_data.mac = sender_mac;
    if (func) begin
      push_data.cmd = arpm_pkg::CMD_CLEAR;
    end else if (is_request) begin
      push_data.cmd = arpm_pkg::CMD_SEARCH;
    end else begin
      push_data.cmd = arpm_pkg::CMD_IGNORE;
    end
  end

endmodule

/* rtl/arpm_queue.sv */
// short command queue between the front end and the table engine
module arpm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  arpm_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output arpm_pkg::q_entry_t q_data
);

  localparam int PW = (arpm_pkg::QUEUE_DEPTH > 1) ? $clog2(arpm_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(arpm_pkg::QUEUE_DEPTH + 1);

  arpm_pkg::q_entry_t slots [arpm_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign full    = (fill == CW'(arpm_pkg::QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(arpm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(arpm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* rtl/arpm_back.sv */
// table engine: sequential search, learning and clearing of ip/mac bindings
module arpm_back #(
  parameter int TABLE_ENTRIES = arpm_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  arpm_pkg::q_entry_t q_data,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         event_res,
  output logic [47:0]        bound_mac,
  output logic [6:0]         entries_used
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic [31:0] ip_mem  [TABLE_ENTRIES];
  logic [47:0] mac_mem [TABLE_ENTRIES];

  arpm_pkg::back_state_t state;
  arpm_pkg::back_state_t state_next;
  arpm_pkg::q_entry_t    cur;
  arpm_pkg::event_t      res_ev;
  arpm_pkg::event_t      set_ev;
  logic [47:0]           res_mac;
  logic [47:0]           set_mac;
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic [31:0]           rd_ip;
  logic [47:0]           rd_mac;
  logic                  rd_vld;
  logic                  rd_en;
  logic                  wr_en;
  logic                  clr;
  logic                  set_res;
  logic                  load_out;
  logic                  hit;
  logic                  scan_end;
  logic [CW+6:0]         count_ext;

  assign hit       = rd_vld && (rd_ip == cur.ip);
  assign scan_end  = (idx == count);
  assign count_ext = {7'd0, count};

  always_comb begin
    state_next = state;
    case (state)
      arpm_pkg::S_IDLE: begin
        if (q_valid) begin
          state_next = (q_data.cmd == arpm_pkg::CMD_SEARCH) ? arpm_pkg::S_SCAN
                                                            : arpm_pkg::S_EMIT;
        end
      end
      arpm_pkg::S_SCAN: begin
        if (hit || scan_end) begin
          state_next = arpm_pkg::S_EMIT;
        end
      end
      arpm_pkg::S_EMIT: begin
        if (load_out) begin
          state_next = arpm_pkg::S_IDLE;
        end
      end
      default: state_next = arpm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    clr      = 1'b0;
    set_res  = 1'b0;
    set_ev   = arpm_pkg::EV_IGNORED;
    set_mac  = '0;
    load_out = 1'b0;
    case (state)
      arpm_pkg::S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_data.cmd)
            arpm_pkg::CMD_CLEAR: begin
              clr     = 1'b1;
              set_res = 1'b1;
              set_ev  = arpm_pkg::EV_CLEARED;
            end
            arpm_pkg::CMD_SEARCH: ;
            default: begin
              set_res = 1'b1;
              set_ev  = arpm_pkg::EV_IGNORED;
            end
          endcase
        end
      end
      arpm_pkg::S_SCAN: begin
        // read of entry idx issued each cycle, compared in the next cycle from the registered read data
        if (hit) begin
          set_res = 1'b1;
          set_ev  = (rd_mac == cur.mac) ? arpm_pkg::EV_SAME : arpm_pkg::EV_CONFLICT;
          set_mac = rd_mac;
        end else if (scan_end) begin
          set_res = 1'b1;
          if (count == CW'(TABLE_ENTRIES)) begin
            set_ev = arpm_pkg::EV_FULL;
          end else begin
            wr_en  = 1'b1;
            set_ev = arpm_pkg::EV_LEARNED;
          end
        end else begin
          rd_en = 1'b1;
        end
      end
      arpm_pkg::S_EMIT: begin
        load_out = !result_valid || !result_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ip_mem[count[AW-1:0]]  <= cur.ip;
      mac_mem[count[AW-1:0]] <= cur.mac;
    end
    if (rd_en) begin
      rd_ip  <= ip_mem[idx[AW-1:0]];
      rd_mac <= mac_mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
    if (set_res) begin
      res_ev  <= set_ev;
      res_mac <= set_mac;
    end
    if (load_out) begin
      event_res    <= res_ev;
      bound_mac    <= res_mac;
      entries_used <= count_ext[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= arpm_pkg::S_IDLE;
      count        <= '0;
      idx          <= '0;
      rd_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (pop) begin
        idx <= '0;
      end else if (rd_en) begin
        idx <= idx + 1'b1;
      end
      if (clr) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + 1'b1;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
